// ===== rtl/core/v4a_pkg.sv =====
// ---------------------------------------------------------------------------
// v4a_pkg
// Shared types, constants and arithmetic helpers of the vector ALU.
// ---------------------------------------------------------------------------
package v4a_pkg;

   localparam int DATA_WIDTH = 32;
   localparam int FRAC_BITS  = 16;
   localparam int LANES      = 4;
   localparam int SQRT_STEPS = DATA_WIDTH;
   localparam int DIV_STEPS  = DATA_WIDTH;
   localparam int EPS_WIDTH  = 16;

   typedef logic signed [DATA_WIDTH-1:0] word_type;

   typedef enum logic [3:0] {
      OP_ADD    = 4'd0,
      OP_SUB    = 4'd1,
      OP_NEG    = 4'd2,
      OP_SCALE  = 4'd3,
      OP_DIV    = 4'd4,
      OP_LENGTH = 4'd5,
      OP_NORM   = 4'd6,
      OP_DOT    = 4'd7,
      OP_EQ     = 4'd8,
      OP_NE     = 4'd9
   } op_type;

   typedef struct packed {
      logic [3:0] opcode;
      word_type   a_x;
      word_type   a_y;
      word_type   a_z;
      word_type   a_w;
      word_type   b_x;
      word_type   b_y;
      word_type   b_z;
      word_type   b_w;
      word_type   factor;
   } req_type;

   typedef struct packed {
      word_type res_x;
      word_type res_y;
      word_type res_z;
      word_type res_w;
      word_type res_scalar;
      logic     compare_true;
      logic     near_zero_error;
   } rsp_type;

   // per-item data that rides alongside the long arithmetic
   typedef struct packed {
      logic [3:0]                       op;
      logic [LANES-1:0]                 a_neg;
      logic [LANES-1:0][DATA_WIDTH-1:0] a_mag;
      logic                             f_neg;
      logic [DATA_WIDTH-1:0]            f_mag;
      logic [LANES-1:0][DATA_WIDTH-1:0] vec;
      logic [DATA_WIDTH-1:0]            scalar;
      logic                             cmp;
      logic                             err;
      logic [DATA_WIDTH:0]              dvs;
   } side_type;

   localparam logic [DATA_WIDTH-1:0] WORD_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
   localparam logic [DATA_WIDTH-1:0] WORD_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

   function automatic logic [DATA_WIDTH-1:0] sat_sum(input logic signed [DATA_WIDTH:0] v);
      logic [DATA_WIDTH-1:0] r;
      if (v > $signed({2'b00, {(DATA_WIDTH-1){1'b1}}})) begin
         r = WORD_MAX;
      end else if (v < $signed({2'b11, {(DATA_WIDTH-1){1'b0}}})) begin
         r = WORD_MIN;
      end else begin
         r = v[DATA_WIDTH-1:0];
      end
      return r;
   endfunction

   // round to nearest (ties away from zero) by 2^FRAC_BITS, then saturate
   function automatic logic [DATA_WIDTH-1:0] round_sat(input logic signed [2*DATA_WIDTH+1:0] v);
      logic [2*DATA_WIDTH+1:0] m;
      logic [2*DATA_WIDTH+1:0] q;
      logic [DATA_WIDTH-1:0]   r;
      m = v[2*DATA_WIDTH+1] ? (~v + 1'b1) : v;
      q = (m + ((2*DATA_WIDTH+2)'(1) << (FRAC_BITS-1))) >> FRAC_BITS;
      if (v[2*DATA_WIDTH+1]) begin
         if (q > (2*DATA_WIDTH+2)'(WORD_MIN)) begin
            r = WORD_MIN;
         end else begin
            r = ~q[DATA_WIDTH-1:0] + 1'b1;
         end
      end else begin
         if (q > (2*DATA_WIDTH+2)'(WORD_MAX)) begin
            r = WORD_MAX;
         end else begin
            r = q[DATA_WIDTH-1:0];
         end
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/v4a_sqrt.sv =====
// ---------------------------------------------------------------------------
// v4a_sqrt
// Pipelined digit-by-digit square root, one result bit per stage.
// ---------------------------------------------------------------------------
module v4a_sqrt (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       enable,
   input  logic                       in_valid,
   input  logic [2*v4a_pkg::DATA_WIDTH-1:0] in_x,
   input  v4a_pkg::side_type          in_side,
   output logic                       out_valid,
   output logic [2*v4a_pkg::DATA_WIDTH-1:0] out_root,
   output logic [2*v4a_pkg::DATA_WIDTH-1:0] out_rem,
   output v4a_pkg::side_type          out_side
);
   import v4a_pkg::*;

   localparam int XW = 2*DATA_WIDTH;

   logic [XW-1:0]    root_ff [SQRT_STEPS];
   logic [XW-1:0]    rem_ff  [SQRT_STEPS];
   side_type         side_ff [SQRT_STEPS];
   logic [SQRT_STEPS-1:0] valid_ff;

   genvar k;
   generate
      for (k = 0; k < SQRT_STEPS; k++) begin : g_step
         localparam logic [XW-1:0] BIT = XW'(1) << (XW - 2 - 2*k);
         logic [XW-1:0] root_src;
         logic [XW-1:0] rem_src;
         logic [XW-1:0] trial;
         logic [XW-1:0] root_in;
         logic [XW-1:0] rem_in;
         logic          valid_src;
         side_type      side_src;

         if (k == 0) begin : g_first
            assign root_src  = '0;
            assign rem_src   = in_x;
            assign valid_src = in_valid;
            assign side_src  = in_side;
         end else begin : g_next
            assign root_src  = root_ff[k-1];
            assign rem_src   = rem_ff[k-1];
            assign valid_src = valid_ff[k-1];
            assign side_src  = side_ff[k-1];
         end

         always_comb begin
            trial = root_src + BIT;
            if (rem_src >= trial) begin
               rem_in  = rem_src - trial;
               root_in = (root_src >> 1) + BIT;
            end else begin
               rem_in  = rem_src;
               root_in = root_src >> 1;
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (enable) begin
               valid_ff[k] <= valid_src;
            end
            if (enable) begin
               root_ff[k] <= root_in;
               rem_ff[k]  <= rem_in;
               side_ff[k] <= side_src;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = root_ff[SQRT_STEPS-1];
   assign out_rem   = rem_ff[SQRT_STEPS-1];
   assign out_side  = side_ff[SQRT_STEPS-1];

endmodule

// ===== rtl/core/v4a_div.sv =====
// ---------------------------------------------------------------------------
// v4a_div
// Four-lane pipelined restoring divider, rounded fixed-point quotient.
// ---------------------------------------------------------------------------
module v4a_div (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  v4a_pkg::side_type     in_side,
   output logic                  out_valid,
   output logic [v4a_pkg::LANES-1:0][v4a_pkg::DATA_WIDTH-1:0] out_quot,
   output logic [v4a_pkg::LANES-1:0] out_ovf,
   output v4a_pkg::side_type     out_side
);
   import v4a_pkg::*;

   localparam int NW = DATA_WIDTH + FRAC_BITS;

   logic [LANES-1:0][NW-1:0]           num_ff;
   side_type                           num_side_ff;
   logic                               num_valid_ff;

   logic [LANES-1:0][DATA_WIDTH:0]     rem_ff [DIV_STEPS];
   logic [LANES-1:0][DATA_WIDTH-1:0]   nq_ff  [DIV_STEPS];
   logic [LANES-1:0]                   ovf_ff [DIV_STEPS];
   side_type                           side_ff[DIV_STEPS];
   logic [DIV_STEPS-1:0]               valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_valid_ff <= 1'b0;
      end else if (enable) begin
         num_valid_ff <= in_valid;
      end
      if (enable) begin
         for (int i = 0; i < LANES; i++) begin
            num_ff[i] <= {in_side.a_mag[i], {FRAC_BITS{1'b0}}} + NW'(in_side.dvs >> 1);
         end
         num_side_ff <= in_side;
      end
   end

   genvar k;
   generate
      for (k = 0; k < DIV_STEPS; k++) begin : g_step
         logic [LANES-1:0][DATA_WIDTH:0]   rem_src;
         logic [LANES-1:0][DATA_WIDTH-1:0] nq_src;
         logic [LANES-1:0]                 ovf_src;
         logic [LANES-1:0][DATA_WIDTH:0]   rem_in;
         logic [LANES-1:0][DATA_WIDTH-1:0] nq_in;
         logic                             valid_src;
         side_type                         side_src;

         if (k == 0) begin : g_first
            always_comb begin
               for (int i = 0; i < LANES; i++) begin
                  rem_src[i] = (DATA_WIDTH+1)'(num_ff[i][NW-1:DATA_WIDTH]);
                  nq_src[i]  = num_ff[i][DATA_WIDTH-1:0];
                  ovf_src[i] = (DATA_WIDTH+1)'(num_ff[i][NW-1:DATA_WIDTH]) >= num_side_ff.dvs;
               end
            end
            assign valid_src = num_valid_ff;
            assign side_src  = num_side_ff;
         end else begin : g_next
            assign rem_src   = rem_ff[k-1];
            assign nq_src    = nq_ff[k-1];
            assign ovf_src   = ovf_ff[k-1];
            assign valid_src = valid_ff[k-1];
            assign side_src  = side_ff[k-1];
         end

         always_comb begin
            logic [DATA_WIDTH+1:0] t;
            for (int i = 0; i < LANES; i++) begin
               t = {rem_src[i], nq_src[i][DATA_WIDTH-1]};
               if (t >= {1'b0, side_src.dvs}) begin
                  rem_in[i] = (DATA_WIDTH+1)'(t - {1'b0, side_src.dvs});
                  nq_in[i]  = {nq_src[i][DATA_WIDTH-2:0], 1'b1};
               end else begin
                  rem_in[i] = t[DATA_WIDTH:0];
                  nq_in[i]  = {nq_src[i][DATA_WIDTH-2:0], 1'b0};
               end
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (enable) begin
               valid_ff[k] <= valid_src;
            end
            if (enable) begin
               rem_ff[k]  <= rem_in;
               nq_ff[k]   <= nq_in;
               ovf_ff[k]  <= ovf_src;
               side_ff[k] <= side_src;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_quot  = nq_ff[DIV_STEPS-1];
   assign out_ovf   = ovf_ff[DIV_STEPS-1];
   assign out_side  = side_ff[DIV_STEPS-1];

endmodule

// ===== rtl/core/vector4_alu.sv =====
// ---------------------------------------------------------------------------
// vector4_alu
// Four-component Q16.16 vector ALU, fully pipelined.
// ---------------------------------------------------------------------------
// Every opcode takes the same path from req transfer to rsp valid.
// Throughput: one transfer per cycle; 32 square-root and 32 divider stages
// set the depth. The whole pipe holds while a result waits on rsp_stall.
// Reset: clears all valid bits and sets epsilon to 1; data needs no reset.
module vector4_alu (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  v4a_pkg::req_type  req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output v4a_pkg::rsp_type  rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [v4a_pkg::EPS_WIDTH-1:0] csr_data
);
   import v4a_pkg::*;

   localparam int PW = 2*DATA_WIDTH;

   logic                     en;
   logic [EPS_WIDTH-1:0]     eps_ff;

   word_type                 a_v [LANES];
   word_type                 b_v [LANES];
   side_type                 s1_side_in;
   logic signed [PW-1:0]     s1_prod_in [LANES];

   logic                     s1_valid_ff;
   side_type                 s1_side_ff;
   logic signed [PW-1:0]     s1_prod_ff [LANES];

   side_type                 s2_side_in;
   logic                     s2_valid_ff;
   side_type                 s2_side_ff;
   logic signed [PW:0]       s2_pair_ff [2];

   logic                     s3_valid_ff;
   side_type                 s3_side_ff;
   logic signed [PW+1:0]     s3_total_ff;

   side_type                 sq_side_in;
   logic [PW-1:0]            sq_x_in;
   logic                     sq_valid;
   logic [PW-1:0]            sq_root;
   logic [PW-1:0]            sq_rem;
   side_type                 sq_side;

   logic [DATA_WIDTH:0]      len;
   side_type                 ln_side_in;
   logic                     ln_valid_ff;
   side_type                 ln_side_ff;

   logic                     dv_valid;
   logic [LANES-1:0][DATA_WIDTH-1:0] dv_quot;
   logic [LANES-1:0]         dv_ovf;
   side_type                 dv_side;

   rsp_type                  rsp_in;
   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         eps_ff <= EPS_WIDTH'(1);
      end else if (csr_valid && csr_ready) begin
         eps_ff <= csr_data;
      end
   end

   always_comb begin
      logic signed [DATA_WIDTH-1:0] opb;
      a_v[0] = req_data.a_x;
      a_v[1] = req_data.a_y;
      a_v[2] = req_data.a_z;
      a_v[3] = req_data.a_w;
      b_v[0] = req_data.b_x;
      b_v[1] = req_data.b_y;
      b_v[2] = req_data.b_z;
      b_v[3] = req_data.b_w;
      s1_side_in        = '0;
      s1_side_in.op     = req_data.opcode;
      s1_side_in.f_neg  = req_data.factor[DATA_WIDTH-1];
      s1_side_in.f_mag  = req_data.factor[DATA_WIDTH-1] ? (~req_data.factor + 1'b1)
                                                      : req_data.factor;
      s1_side_in.cmp    = (req_data.opcode == OP_NE);
      if ((a_v[0] == b_v[0]) && (a_v[1] == b_v[1]) && (a_v[2] == b_v[2])
          && (a_v[3] == b_v[3])) begin
         s1_side_in.cmp = (req_data.opcode == OP_EQ);
      end
      for (int i = 0; i < LANES; i++) begin
         s1_side_in.a_neg[i] = a_v[i][DATA_WIDTH-1];
         s1_side_in.a_mag[i] = a_v[i][DATA_WIDTH-1] ? (~a_v[i] + 1'b1) : a_v[i];
         case (req_data.opcode)
            OP_ADD:  s1_side_in.vec[i] = sat_sum($signed({a_v[i][DATA_WIDTH-1], a_v[i]})
                                          + $signed({b_v[i][DATA_WIDTH-1], b_v[i]}));
            OP_SUB:  s1_side_in.vec[i] = sat_sum($signed({a_v[i][DATA_WIDTH-1], a_v[i]})
                                          - $signed({b_v[i][DATA_WIDTH-1], b_v[i]}));
            OP_NEG:  s1_side_in.vec[i] = sat_sum(-$signed({a_v[i][DATA_WIDTH-1], a_v[i]}));
            default: s1_side_in.vec[i] = '0;
         endcase
         if (req_data.opcode == OP_DOT) begin
            opb = b_v[i];
         end else if (req_data.opcode == OP_SCALE) begin
            opb = req_data.factor;
         end else begin
            opb = a_v[i];
         end
         s1_prod_in[i] = PW'(a_v[i]) * PW'(opb);
      end
   end

   always_comb begin
      s2_side_in = s1_side_ff;
      if (s1_side_ff.op == OP_SCALE) begin
         for (int i = 0; i < LANES; i++) begin
            s2_side_in.vec[i] = round_sat((PW+2)'(s1_prod_ff[i]));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= req_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
      if (en) begin
         s1_side_ff <= s1_side_in;
         s1_prod_ff <= s1_prod_in;
         s2_side_ff <= s2_side_in;
         s2_pair_ff[0] <= (PW+1)'(s1_prod_ff[0]) + (PW+1)'(s1_prod_ff[1]);
         s2_pair_ff[1] <= (PW+1)'(s1_prod_ff[2]) + (PW+1)'(s1_prod_ff[3]);
         s3_side_ff    <= s2_side_ff;
         s3_total_ff   <= (PW+2)'(s2_pair_ff[0]) + (PW+2)'(s2_pair_ff[1]);
      end
   end

   always_comb begin
      sq_side_in = s3_side_ff;
      if (s3_side_ff.op == OP_DOT) begin
         sq_side_in.scalar = round_sat(s3_total_ff);
      end
      sq_x_in = s3_total_ff[PW] ? {PW{1'b1}} : s3_total_ff[PW-1:0];
   end

   v4a_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (s3_valid_ff),
      .in_x      (sq_x_in),
      .in_side   (sq_side_in),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_rem   (sq_rem),
      .out_side  (sq_side)
   );

   always_comb begin
      len        = sq_root[DATA_WIDTH:0] + (DATA_WIDTH+1)'(sq_rem > sq_root);
      ln_side_in = sq_side;
      if (sq_side.op == OP_LENGTH) begin
         ln_side_in.scalar = (len > (DATA_WIDTH+1)'(WORD_MAX)) ? WORD_MAX
                                                               : len[DATA_WIDTH-1:0];
      end
      ln_side_in.dvs = (sq_side.op == OP_DIV) ? {1'b0, sq_side.f_mag} : len;
      ln_side_in.err = ((sq_side.op == OP_DIV) || (sq_side.op == OP_NORM))
                       && (ln_side_in.dvs <= (DATA_WIDTH+1)'(eps_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ln_valid_ff <= 1'b0;
      end else if (en) begin
         ln_valid_ff <= sq_valid;
      end
      if (en) begin
         ln_side_ff <= ln_side_in;
      end
   end

   v4a_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (en),
      .in_valid  (ln_valid_ff),
      .in_side   (ln_side_ff),
      .out_valid (dv_valid),
      .out_quot  (dv_quot),
      .out_ovf   (dv_ovf),
      .out_side  (dv_side)
   );

   always_comb begin
      logic [LANES-1:0][DATA_WIDTH-1:0] vec;
      logic                             neg;
      logic                             divides;
      divides = (dv_side.op == OP_DIV) || (dv_side.op == OP_NORM);
      for (int i = 0; i < LANES; i++) begin
         neg = dv_side.a_neg[i] ^ ((dv_side.op == OP_DIV) && dv_side.f_neg);
         if (!divides) begin
            vec[i] = dv_side.vec[i];
         end else if (dv_side.err) begin
            vec[i] = '0;
         end else if (neg) begin
            vec[i] = (dv_ovf[i] || (dv_quot[i] > WORD_MIN)) ? WORD_MIN
                                                            : (~dv_quot[i] + 1'b1);
         end else begin
            vec[i] = (dv_ovf[i] || (dv_quot[i] > WORD_MAX)) ? WORD_MAX : dv_quot[i];
         end
      end
      rsp_in.res_x           = vec[0];
      rsp_in.res_y           = vec[1];
      rsp_in.res_z           = vec[2];
      rsp_in.res_w           = vec[3];
      rsp_in.res_scalar      = dv_side.scalar;
      rsp_in.compare_true    = dv_side.cmp;
      rsp_in.near_zero_error = dv_side.err;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         rsp_valid_ff <= dv_valid;
      end
      if (en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ===== rtl/core/v4a_checker.sv =====
// ---------------------------------------------------------------------------
// v4a_checker
// Port-level checks of the vector ALU, bound to the top level.
// ---------------------------------------------------------------------------
module v4a_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input v4a_pkg::rsp_type  rsp_data
);
   import v4a_pkg::*;

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled transfer changed");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.near_zero_error |->
         rsp_data.res_x == '0 && rsp_data.res_y == '0 && rsp_data.res_z == '0
         && rsp_data.res_w == '0 && rsp_data.res_scalar == '0 && !rsp_data.compare_true)
      else $error("error result not all zero");

   a_cmp_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.compare_true |->
         rsp_data.res_x == '0 && rsp_data.res_scalar == '0)
      else $error("compare result carries data");

   a_stall_tracks: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input held without a stalled result");

endmodule

bind vector4_alu v4a_checker u_v4a_checker (.*);
